[rtl/nntt_pkg.sv]
// nntt_pkg: shared types and constants of the nearest-neighbour track table
// used by nearest_neighbour_track_table, no dependencies
package nntt_pkg;

  localparam int DefMaxTracks = 32;
  localparam int DefTrailLen  = 16;

  localparam logic [31:0] GateReset      = 32'd1048576;
  localparam logic [3:0]  MissLimitReset = 4'd3;
  localparam logic [3:0]  MissedMax      = 4'd15;

  typedef enum logic [1:0] {
    CMD_FRAME_BEGIN = 2'd0,
    CMD_DETECTION   = 2'd1,
    CMD_FRAME_END   = 2'd2,
    CMD_READ_POINT  = 2'd3
  } nntt_cmd_e;

  typedef enum logic {
    CFG_GATE_DISTANCE_SQ = 1'b0,
    CFG_MISS_LIMIT       = 1'b1
  } nntt_cfg_e;

  // input payload, frame_index in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic [3:0]         point_select;
    logic [4:0]         slot_select;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
    logic [3:0]         obj_class;
    logic [31:0]        frame_index;
  } item_t;

  // result payload, track_id in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic               slot_valid;
    logic [3:0]         track_class;
    logic [4:0]         trail_length;
    logic signed [15:0] point_y;
    logic signed [15:0] point_x;
    logic [5:0]         removed_count;
    logic [5:0]         live_tracks;
    logic               no_slot;
    logic               is_new;
    logic [4:0]         slot_index;
    logic [15:0]        track_id;
  } result_t;

endpackage

[rtl/nntt_trail_mem.sv]
// nntt_trail_mem: trail point store, x and y side by side
// one write and one registered read per cycle; no dependencies
module nntt_trail_mem #(
  parameter int Depth = 512,
  parameter int Aw    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [15:0]   wx_i,
  input  logic [15:0]   wy_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [15:0]   rx_o,
  output logic [15:0]   ry_o
);

  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wy_i, wx_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      {ry_o, rx_o} <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/nearest_neighbour_track_table.sv]
// nearest_neighbour_track_table: track table with greedy nearest-neighbour association
// uses nntt_pkg and nntt_trail_mem
//
// One item is processed at a time and gives one result. A detection scans every live
// slot with one shared 17x17 multiplier: each slot of the same class that is unused and
// not empty goes through read, x square, y square and sum, and compare; other slots
// are skipped, and then the point is appended. A frame end checks each slot, and a
// removal that moves the last slot copies its trail through the single memory port.
// A waiting result does not block the next item.
module nearest_neighbour_track_table
  import nntt_pkg::*;
#(
  parameter int MAX_TRACKS = DefMaxTracks,
  parameter int TRAIL_LEN  = DefTrailLen
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // frame_index, obj_class, pos_x, pos_y, slot_select, point_select, zero fill
  input  nntt_pkg::item_t      s_axis_tdata,
  // command
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // track_id, slot_index, is_new, no_slot, live_tracks, removed_count,
  // point_x, point_y, trail_length, track_class, slot_valid, zero fill
  output nntt_pkg::result_t    m_axis_tdata
);

  localparam int Sw    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int Cw    = $clog2(MAX_TRACKS + 1);
  localparam int Tw    = (TRAIL_LEN > 1) ? $clog2(TRAIL_LEN) : 1;
  localparam int Lw    = $clog2(TRAIL_LEN + 1);
  localparam int Rw    = ((Lw > 4) ? Lw : 4) + 1;
  localparam int Depth = MAX_TRACKS * TRAIL_LEN;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef struct packed {
    logic [15:0]   id;
    logic [3:0]    cls;
    logic [Lw-1:0] len;
    logic [Tw-1:0] head;
    logic [3:0]    missed;
  } meta_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FB, ST_SC_RD, ST_SC_MX, ST_SC_MY, ST_SC_CMP, ST_NEW, ST_APPEND,
    ST_FE_CHK, ST_MV_RD, ST_MV_WR, ST_MV_META, ST_RD, ST_RD_WAIT, ST_DONE
  } state_e;

  state_e          state_q;
  item_t           item_q;
  logic [31:0]     gate_q;
  logic [3:0]      limit_q;
  logic [Cw-1:0]   live_q;
  logic [15:0]     next_id_q;
  logic [31:0]     prev_frame_q;
  logic            have_prev_q;
  logic [Cw-1:0]   t_q;
  logic [Sw-1:0]   best_q;
  logic            found_q;
  logic            fresh_q;
  logic [33:0]     best_d_q;
  logic [33:0]     sq_q;
  logic [33:0]     acc_q;
  logic [Cw-1:0]   removed_q;
  logic [Tw-1:0]   k_q;
  logic            m_valid_q;
  result_t         res_q;
  result_t         m_data_q;
  result_t         res_out;

  meta_t           meta_q [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] used_q;

  logic [Sw-1:0]   rptr;
  meta_t           meta_rd;
  logic            meta_we;
  logic [Sw-1:0]   meta_wptr;
  meta_t           meta_wd;
  logic            mem_we, mem_re;
  logic [Aw-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wx, mem_wy, mem_rx, mem_ry;
  logic [Sw-1:0]   t_slot;
  logic            scan_ok;
  logic [3:0]      m2;
  logic            remove;
  logic            rd_slot_ok, rd_point_ok;
  logic signed [16:0] dx, dy, mul_op;
  logic signed [33:0] prod;

  function automatic logic [Tw-1:0] ring_wrap(input logic [Rw-1:0] v);
    logic [Rw-1:0] w;
    w = (v >= Rw'(TRAIL_LEN)) ? v - Rw'(TRAIL_LEN) : v;
    return Tw'(w);
  endfunction

  function automatic logic [Aw-1:0] trail_addr(input logic [Sw-1:0] s, input logic [Tw-1:0] p);
    return Aw'(Aw'(s) * Aw'(TRAIL_LEN) + Aw'(p));
  endfunction

  nntt_trail_mem #(.Depth(Depth), .Aw(Aw)) u_trail (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wx_i    (mem_wx),
    .wy_i    (mem_wy),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rx_o    (mem_rx),
    .ry_o    (mem_ry)
  );

  assign t_slot  = t_q[Sw-1:0];
  assign meta_rd = meta_q[rptr];
  assign scan_ok = !used_q[t_slot] && (meta_rd.cls == item_q.obj_class) && (meta_rd.len != '0);
  assign m2      = (meta_rd.missed == MissedMax) ? MissedMax : meta_rd.missed + 4'd1;
  assign remove  = m2 > limit_q;
  assign rd_slot_ok  = 32'(item_q.slot_select) < 32'(live_q);
  assign rd_point_ok = 32'(item_q.point_select) < 32'(meta_rd.len);

  // shared squaring unit
  assign dx     = {mem_rx[15], mem_rx} - {item_q.pos_x[15], item_q.pos_x};
  assign dy     = {mem_ry[15], mem_ry} - {item_q.pos_y[15], item_q.pos_y};
  assign mul_op = (state_q == ST_SC_MX) ? dx : dy;
  assign prod   = mul_op * mul_op;

  always_comb begin
    res_out             = res_q;
    res_out.live_tracks = 6'(live_q);
  end

  always_comb begin
    rptr      = t_slot;
    meta_we   = 1'b0;
    meta_wptr = t_slot;
    meta_wd   = meta_rd;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wx    = '0;
    mem_wy    = '0;
    case (state_q)
      ST_SC_RD: begin
        mem_re    = (t_q < live_q) && scan_ok;
        mem_raddr = trail_addr(t_slot,
                      ring_wrap(Rw'(meta_rd.head) + Rw'(meta_rd.len) - Rw'(1)));
      end
      ST_NEW: begin
        meta_we   = 1'b1;
        meta_wptr = live_q[Sw-1:0];
        meta_wd   = '{id: next_id_q, cls: item_q.obj_class, len: '0, head: '0, missed: '0};
      end
      ST_APPEND: begin
        rptr      = best_q;
        meta_wptr = best_q;
        meta_we   = 1'b1;
        mem_we    = 1'b1;
        mem_wx    = item_q.pos_x;
        mem_wy    = item_q.pos_y;
        meta_wd.missed = '0;
        if (32'(meta_rd.len) >= TRAIL_LEN) begin
          mem_waddr    = trail_addr(best_q, meta_rd.head);
          meta_wd.head = ring_wrap(Rw'(meta_rd.head) + Rw'(1));
        end else begin
          mem_waddr   = trail_addr(best_q, ring_wrap(Rw'(meta_rd.head) + Rw'(meta_rd.len)));
          meta_wd.len = meta_rd.len + Lw'(1);
        end
      end
      ST_FE_CHK: begin
        meta_we        = (t_q < live_q) && !used_q[t_slot] && !remove;
        meta_wd.missed = m2;
      end
      ST_MV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = trail_addr(live_q[Sw-1:0], k_q);
      end
      ST_MV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = trail_addr(t_slot, k_q);
        mem_wx    = mem_rx;
        mem_wy    = mem_ry;
      end
      ST_MV_META: begin
        rptr    = live_q[Sw-1:0];
        meta_we = 1'b1;
      end
      ST_RD: begin
        rptr      = Sw'(item_q.slot_select);
        mem_re    = rd_slot_ok && rd_point_ok;
        mem_raddr = trail_addr(Sw'(item_q.slot_select),
                      ring_wrap(Rw'(meta_rd.head) + Rw'(item_q.point_select)));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_q[meta_wptr] <= meta_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gate_q       <= GateReset;
      limit_q      <= MissLimitReset;
      live_q       <= '0;
      next_id_q    <= 16'd1;
      prev_frame_q <= '0;
      have_prev_q  <= 1'b0;
      used_q       <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (nntt_cfg_e'(cfg_index_i))
          CFG_GATE_DISTANCE_SQ: gate_q <= cfg_data_i;
          CFG_MISS_LIMIT:       limit_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            item_q    <= s_axis_tdata;
            res_q     <= '0;
            t_q       <= '0;
            removed_q <= '0;
            found_q   <= 1'b0;
            fresh_q   <= 1'b0;
            best_q    <= '0;
            best_d_q  <= {2'b00, gate_q};
            case (nntt_cmd_e'(s_axis_tuser))
              CMD_FRAME_BEGIN: state_q <= ST_FB;
              CMD_DETECTION:   state_q <= ST_SC_RD;
              CMD_FRAME_END:   state_q <= ST_FE_CHK;
              default:         state_q <= ST_RD;
            endcase
          end
        end
        ST_FB: begin
          if (have_prev_q && item_q.frame_index != prev_frame_q + 32'd1) begin
            live_q <= '0;
          end
          used_q       <= '0;
          prev_frame_q <= item_q.frame_index;
          have_prev_q  <= 1'b1;
          state_q      <= ST_DONE;
        end
        ST_SC_RD: begin
          if (t_q >= live_q) begin
            if (found_q) begin
              state_q <= ST_APPEND;
            end else if (32'(live_q) < MAX_TRACKS) begin
              state_q <= ST_NEW;
            end else begin
              res_q.no_slot <= 1'b1;
              state_q       <= ST_DONE;
            end
          end else if (scan_ok) begin
            state_q <= ST_SC_MX;
          end else begin
            t_q <= t_q + Cw'(1);
          end
        end
        ST_SC_MX: begin
          sq_q    <= prod;
          state_q <= ST_SC_MY;
        end
        ST_SC_MY: begin
          acc_q   <= sq_q + prod;
          state_q <= ST_SC_CMP;
        end
        ST_SC_CMP: begin
          // strict compare keeps ties on the lowest slot
          if (acc_q < best_d_q) begin
            best_d_q <= acc_q;
            best_q   <= t_slot;
            found_q  <= 1'b1;
          end
          t_q     <= t_q + Cw'(1);
          state_q <= ST_SC_RD;
        end
        ST_NEW: begin
          best_q    <= live_q[Sw-1:0];
          live_q    <= live_q + Cw'(1);
          next_id_q <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
          fresh_q   <= 1'b1;
          state_q   <= ST_APPEND;
        end
        ST_APPEND: begin
          used_q[best_q]     <= 1'b1;
          res_q.track_id     <= meta_rd.id;
          res_q.slot_index   <= 5'(best_q);
          res_q.is_new       <= fresh_q;
          res_q.trail_length <= 5'(meta_wd.len);
          res_q.track_class  <= meta_rd.cls;
          res_q.slot_valid   <= 1'b1;
          state_q            <= ST_DONE;
        end
        ST_FE_CHK: begin
          if (t_q >= live_q) begin
            used_q              <= '0;
            res_q.removed_count <= 6'(removed_q);
            state_q             <= ST_DONE;
          end else if (used_q[t_slot] || !remove) begin
            t_q <= t_q + Cw'(1);
          end else begin
            live_q    <= live_q - Cw'(1);
            removed_q <= removed_q + Cw'(1);
            if (t_q != live_q - Cw'(1)) begin
              k_q     <= '0;
              state_q <= ST_MV_RD;
            end else begin
              t_q <= t_q + Cw'(1);
            end
          end
        end
        ST_MV_RD: begin
          state_q <= ST_MV_WR;
        end
        ST_MV_WR: begin
          k_q <= k_q + Tw'(1);
          if (32'(k_q) == TRAIL_LEN - 1) begin
            state_q <= ST_MV_META;
          end else begin
            state_q <= ST_MV_RD;
          end
        end
        ST_MV_META: begin
          // moved slot keeps its used mark and is examined again at this place
          used_q[t_slot] <= used_q[live_q[Sw-1:0]];
          state_q        <= ST_FE_CHK;
        end
        ST_RD: begin
          if (rd_slot_ok) begin
            res_q.track_id     <= meta_rd.id;
            res_q.slot_index   <= item_q.slot_select;
            res_q.trail_length <= 5'(meta_rd.len);
            res_q.track_class  <= meta_rd.cls;
          end
          if (rd_slot_ok && rd_point_ok) begin
            res_q.slot_valid <= 1'b1;
            state_q          <= ST_RD_WAIT;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_RD_WAIT: begin
          res_q.point_x <= mem_rx;
          res_q.point_y <= mem_ry;
          state_q       <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_out;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_q) <= MAX_TRACKS)
    else $error("live track count above table size");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != 16'd0)
    else $error("track id zero would be handed out");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SC_MX || state_q == ST_SC_MY || state_q == ST_SC_CMP) |-> t_q < live_q)
    else $error("distance scan past the live slots");

  a_new_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEW) |=> (32'(live_q) <= MAX_TRACKS && fresh_q))
    else $error("new track opened without room");

endmodule
